[rtl/rsps_pkg.sv]
`default_nettype none
package rsps_pkg;
    localparam int unsigned MAX_DIRECTIONS_DEF = 1024;
    localparam logic [31:0] MAX_EVAL_RESET = 32'd100000000;
    localparam logic [15:0] ONE_Q15 = 16'h8000;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_EVAL  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // controller -> datapath
    typedef struct packed {
        logic take;        // latch inputs
        logic do_load;
        logic do_clear;
        logic mat_step;    // matrix build stage
        logic walk_start;
        logic finish_eval;
    } dp_ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic walk_done;
    } dp_stat_t;
endpackage
`default_nettype wire

[rtl/rsps_datapath.sv]
`default_nettype none
module rsps_datapath
    import rsps_pkg::*;
#(
    parameter int unsigned MAX_DIRECTIONS = MAX_DIRECTIONS_DEF
) (
    input  wire  logic               clk,
    input  wire  logic               rst_n,
    input  wire  dp_ctrl_t           ctrl,
    output dp_stat_t                 stat,
    input  wire  logic signed [15:0] dir_x,
    input  wire  logic signed [15:0] dir_y,
    input  wire  logic signed [15:0] dir_z,
    input  wire  logic signed [15:0] quat_w,
    input  wire  logic signed [15:0] quat_x,
    input  wire  logic signed [15:0] quat_y,
    input  wire  logic signed [15:0] quat_z,
    input  wire  logic        [31:0] max_eval,
    output logic              [15:0] peak_value,
    output logic                     improved,
    output logic              [15:0] best_peak,
    output logic              [15:0] base_peak,
    output logic                     more_wanted,
    output logic              [31:0] eval_count,
    output logic signed       [15:0] best_w,
    output logic signed       [15:0] best_x,
    output logic signed       [15:0] best_y,
    output logic signed       [15:0] best_z,
    output logic                     load_overflow
);
    localparam int unsigned AW = (MAX_DIRECTIONS > 1) ? $clog2(MAX_DIRECTIONS) : 1;
    localparam int unsigned CW = $clog2(MAX_DIRECTIONS + 1);

    logic [47:0] mem [MAX_DIRECTIONS];

    logic [CW-1:0] count_reg;
    logic [15:0]   orig_reg, min_reg, peak_reg;
    logic signed [15:0] bw_reg, bx_reg, by_reg, bz_reg;
    logic [31:0]   evals_reg;
    logic          impr_reg, ovf_reg;
    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [15:0] dx_reg, dy_reg, dz_reg;

    // matrix build: 9 products, one per cycle via a shared multiplier, then combine
    logic [3:0] mstep_reg;
    logic signed [31:0] prod_reg [9];
    logic signed [33:0] m_reg [9];

    // walk
    logic [CW-1:0] rd_idx_reg;
    logic          walking_reg;
    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic [47:0]   rd_data_reg;
    logic signed [49:0] p_reg [9];
    logic signed [51:0] s_reg [3];
    logic [15:0]   c_reg [3];

    assign peak_value    = peak_reg;
    assign improved      = impr_reg;
    assign best_peak     = min_reg;
    assign base_peak     = orig_reg;
    assign more_wanted   = evals_reg < max_eval;
    assign eval_count    = evals_reg;
    assign best_w = bw_reg;
    assign best_x = bx_reg;
    assign best_y = by_reg;
    assign best_z = bz_reg;
    assign load_overflow = ovf_reg;
    assign stat.walk_done = !walking_reg && !v1_reg && !v2_reg && !v3_reg && !v4_reg
                            && !ctrl.walk_start;

    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        logic [16:0] e;
        e = v[15] ? -{v[15], v} : {v[15], v};
        return e[15:0];
    endfunction

    function automatic logic [15:0] rnd(input logic signed [51:0] a);
        logic [51:0] m;
        logic [51:0] r;
        m = a[51] ? -a : a;
        r = (m + 52'(1 << 29)) >> 30;
        return (r > 52'(ONE_Q15)) ? ONE_Q15 : r[15:0];
    endfunction

    // shared multiplier operand select
    logic signed [15:0] ma, mb;
    always_comb
    begin
        case (mstep_reg)
            4'd0: begin ma = qx_reg; mb = qx_reg; end
            4'd1: begin ma = qy_reg; mb = qy_reg; end
            4'd2: begin ma = qz_reg; mb = qz_reg; end
            4'd3: begin ma = qx_reg; mb = qy_reg; end
            4'd4: begin ma = qx_reg; mb = qz_reg; end
            4'd5: begin ma = qy_reg; mb = qz_reg; end
            4'd6: begin ma = qx_reg; mb = qw_reg; end
            4'd7: begin ma = qy_reg; mb = qw_reg; end
            default: begin ma = qz_reg; mb = qw_reg; end
        endcase
    end

    logic [AW-1:0] rd_addr;
    assign rd_addr = rd_idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.do_load && count_reg < CW'(MAX_DIRECTIONS))
            mem[count_reg[AW-1:0]] <= {dx_reg, dy_reg, dz_reg};
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mat_step)
        begin
            if (mstep_reg < 4'd9)
                prod_reg[mstep_reg] <= ma * mb;
            else
            begin
                // xx=0 yy=1 zz=2 xy=3 xz=4 yz=5 xw=6 yw=7 zw=8
                m_reg[0] <= 34'sd1073741824 - 2 * (34'(prod_reg[1]) + 34'(prod_reg[2]));
                m_reg[1] <= 2 * (34'(prod_reg[3]) - 34'(prod_reg[8]));
                m_reg[2] <= 2 * (34'(prod_reg[4]) + 34'(prod_reg[7]));
                m_reg[3] <= 2 * (34'(prod_reg[3]) + 34'(prod_reg[8]));
                m_reg[4] <= 34'sd1073741824 - 2 * (34'(prod_reg[0]) + 34'(prod_reg[2]));
                m_reg[5] <= 2 * (34'(prod_reg[5]) - 34'(prod_reg[6]));
                m_reg[6] <= 2 * (34'(prod_reg[4]) - 34'(prod_reg[7]));
                m_reg[7] <= 2 * (34'(prod_reg[5]) + 34'(prod_reg[6]));
                m_reg[8] <= 34'sd1073741824 - 2 * (34'(prod_reg[0]) + 34'(prod_reg[1]));
            end
        end
        for (int k = 0; k < 9; k++)
            p_reg[k] <= m_reg[k] * $signed(rd_data_reg[47 - 16*(k%3) -: 16]);
        for (int k = 0; k < 3; k++)
        begin
            s_reg[k] <= 52'(p_reg[3*k]) + 52'(p_reg[3*k+1]) + 52'(p_reg[3*k+2]);
            c_reg[k] <= rnd(s_reg[k]);
        end
        if (ctrl.take)
        begin
            qw_reg <= quat_w; qx_reg <= quat_x; qy_reg <= quat_y; qz_reg <= quat_z;
            dx_reg <= dir_x; dy_reg <= dir_y; dz_reg <= dir_z;
        end
    end

    logic [15:0] cmax;
    always_comb
    begin
        cmax = c_reg[0];
        if (c_reg[1] > cmax) cmax = c_reg[1];
        if (c_reg[2] > cmax) cmax = c_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0; orig_reg <= '0; min_reg <= ONE_Q15; peak_reg <= '0;
            bw_reg <= '0; bx_reg <= '0; by_reg <= '0; bz_reg <= '0;
            evals_reg <= '0; impr_reg <= 1'b0; ovf_reg <= 1'b0;
            mstep_reg <= '0; rd_idx_reg <= '0; walking_reg <= 1'b0;
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.take)
            begin
                peak_reg <= '0; impr_reg <= 1'b0; ovf_reg <= 1'b0; mstep_reg <= '0;
            end
            if (ctrl.mat_step)
                mstep_reg <= mstep_reg + 4'd1;
            if (ctrl.do_load)
            begin
                if (count_reg < CW'(MAX_DIRECTIONS))
                begin
                    count_reg <= count_reg + CW'(1);
                    if (abs16(dx_reg) > orig_reg || abs16(dy_reg) > orig_reg
                        || abs16(dz_reg) > orig_reg)
                    begin
                        orig_reg <= (abs16(dx_reg) > abs16(dy_reg))
                            ? ((abs16(dx_reg) > abs16(dz_reg)) ? abs16(dx_reg) : abs16(dz_reg))
                            : ((abs16(dy_reg) > abs16(dz_reg)) ? abs16(dy_reg) : abs16(dz_reg));
                    end
                end
                else
                    ovf_reg <= 1'b1;
            end
            if (ctrl.do_clear)
            begin
                count_reg <= '0; orig_reg <= '0; min_reg <= ONE_Q15;
                bw_reg <= '0; bx_reg <= '0; by_reg <= '0; bz_reg <= '0;
                evals_reg <= '0;
            end
            // walk pipeline: addr -> rd_data -> p -> s -> c
            v1_reg <= walking_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (ctrl.walk_start)
            begin
                rd_idx_reg  <= '0;
                walking_reg <= (count_reg != '0);
            end
            else if (walking_reg)
            begin
                if (rd_idx_reg + CW'(1) >= count_reg)
                    walking_reg <= 1'b0;
                rd_idx_reg <= rd_idx_reg + CW'(1);
            end
            if (v4_reg && cmax > peak_reg)
                peak_reg <= cmax;
            if (ctrl.finish_eval)
            begin
                if (peak_reg < min_reg)
                begin
                    min_reg <= peak_reg; impr_reg <= 1'b1;
                    bw_reg <= qw_reg; bx_reg <= qx_reg; by_reg <= qy_reg; bz_reg <= qz_reg;
                end
                if (evals_reg != '1)
                    evals_reg <= evals_reg + 32'd1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(MAX_DIRECTIONS))
        else $error("direction count above capacity");
    assert property (@(posedge clk) disable iff (!rst_n) min_reg <= ONE_Q15)
        else $error("best peak above one");
    assert property (@(posedge clk) disable iff (!rst_n) peak_reg <= ONE_Q15)
        else $error("peak above one");
endmodule
`default_nettype wire

[rtl/rsps_ctrl.sv]
`default_nettype none
module rsps_ctrl
    import rsps_pkg::*;
(
    input  wire  logic       clk,
    input  wire  logic       rst_n,
    input  wire  logic       start,
    input  wire  logic [1:0] cmd,
    input  wire  dp_stat_t   stat,
    output dp_ctrl_t         ctrl,
    output logic             busy,
    output logic             done
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_MAT   = 6'b000100,
        S_WALK  = 6'b001000,
        S_FIN   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] mcnt_reg, mcnt_next;
    logic [1:0] cmd_reg;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        mcnt_next  = mcnt_reg;
        ctrl = '0;
        done = 1'b0;
        unique case (state_reg)
            S_IDLE:
                if (start)
                begin
                    ctrl.take = 1'b1;
                    mcnt_next = '0;
                    state_next = (cmd == CMD_EVAL) ? S_MAT : S_LOAD;
                end
            S_LOAD:
            begin
                ctrl.do_load  = (cmd_reg == CMD_LOAD);
                ctrl.do_clear = (cmd_reg == CMD_CLEAR);
                state_next = S_DONE;
            end
            S_MAT:
            begin
                ctrl.mat_step = 1'b1;
                mcnt_next = mcnt_reg + 4'd1;
                if (mcnt_reg == 4'd9)
                begin
                    ctrl.walk_start = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
                if (stat.walk_done) state_next = S_FIN;
            S_FIN:
            begin
                ctrl.finish_eval = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mcnt_reg  <= '0;
            cmd_reg   <= CMD_NONE;
        end
        else
        begin
            state_reg <= state_next;
            mcnt_reg  <= mcnt_next;
            if (ctrl.take) cmd_reg <= cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg) || 1'b0)
        else $error("state not one-hot");
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy)
        else $error("busy after result");
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accept did not start work");
endmodule
`default_nettype wire

[rtl/rotated_set_peak_search.sv]
`default_nettype none
// Rotated direction-set peak search.
// Input: raise start with cmd and payload; the word is taken at an edge
// with start high and busy low. busy stays high until the result is out.
// Commands: load a direction, evaluate a quaternion, clear.
// Output: one result word per command, shown for one cycle with done high;
// the receiver cannot stall, so it must take it then.
// Sequence: load, clear and unused command go through the load state to
// done. Evaluate builds the matrix on one shared 16x16 multiplier, then
// takes one direction per cycle through the memory read and the
// rotate/round pipeline, flushes the pipeline, then updates.
// Flow: busy drops the cycle after done, so the next word is taken only
// after the result; one item in flight at a time.
// Configuration: cfg_data written when cfg_valid and cfg_ready are high;
// cfg_ready is high while idle.
// Reset: store empty, best peak 1.0, counters zero, limit 100000000.
module rotated_set_peak_search
    import rsps_pkg::*;
#(
    parameter int unsigned MAX_DIRECTIONS = MAX_DIRECTIONS_DEF
) (
    input  wire  logic               clk,
    input  wire  logic               rst_n,
    input  wire  logic               start,
    output logic                     busy,
    output logic                     done,
    input  wire  logic        [1:0]  cmd,
    input  wire  logic signed [15:0] dir_x,
    input  wire  logic signed [15:0] dir_y,
    input  wire  logic signed [15:0] dir_z,
    input  wire  logic signed [15:0] quat_w,
    input  wire  logic signed [15:0] quat_x,
    input  wire  logic signed [15:0] quat_y,
    input  wire  logic signed [15:0] quat_z,
    input  wire  logic               cfg_valid,
    output logic                     cfg_ready,
    input  wire  logic        [31:0] cfg_data,
    output logic              [15:0] peak_value,
    output logic                     improved,
    output logic              [15:0] best_peak,
    output logic              [15:0] base_peak,
    output logic                     more_wanted,
    output logic              [31:0] eval_count,
    output logic signed       [15:0] best_w,
    output logic signed       [15:0] best_x,
    output logic signed       [15:0] best_y,
    output logic signed       [15:0] best_z,
    output logic                     load_overflow
);
    dp_ctrl_t ctrl;
    dp_stat_t stat;
    logic [31:0] max_eval_reg;

    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_eval_reg <= MAX_EVAL_RESET;
        else if (cfg_valid && cfg_ready)
            max_eval_reg <= cfg_data;
    end

    rsps_ctrl u_ctrl (
        .clk, .rst_n, .start, .cmd, .stat, .ctrl, .busy, .done
    );

    rsps_datapath #(.MAX_DIRECTIONS(MAX_DIRECTIONS)) u_dp (
        .clk, .rst_n, .ctrl, .stat,
        .dir_x, .dir_y, .dir_z, .quat_w, .quat_x, .quat_y, .quat_z,
        .max_eval(max_eval_reg),
        .peak_value, .improved, .best_peak, .base_peak, .more_wanted,
        .eval_count, .best_w, .best_x, .best_y, .best_z, .load_overflow
    );
endmodule
`default_nettype wire
